// ----- rtl/core/mrq_pkg.sv -----
`timescale 1ns / 1ps

package mrq_pkg;

  // fixed field widths of the request and result
  localparam int TASK_W   = 6;
  localparam int LEVEL_W  = 3;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 7;
  localparam int CFG_W    = 4;

  // number of active levels after reset
  localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_LIFT   = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_BAD_LEVEL = 2'd2
  } status_t;

  // update command from the sequencer to the level table
  typedef struct packed {
    logic               do_insert;
    logic               do_pop;
    logic               do_lift;
    logic [LEVEL_W-1:0] level;
    logic [TASK_W-1:0]  task_id;
  } tbl_cmd_t;

  // lookups from the level table
  typedef struct packed {
    logic               anchor_valid;
    logic [TASK_W-1:0]  anchor_tail;
    logic               low_valid;
    logic [LEVEL_W-1:0] low_level;
  } tbl_info_t;

  // result held between the two phases of a request
  typedef struct packed {
    status_t            status;
    logic               popped_valid;
    logic [TASK_W-1:0]  popped_task;
    logic [LEVEL_W-1:0] popped_level;
  } res_t;

endpackage

// ----- rtl/core/mrq_if.sv -----
`timescale 1ns / 1ps

// request channel
interface mrq_in_if import mrq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [TASK_W-1:0]  task_id;
  logic [LEVEL_W-1:0] level;

  modport source (output valid, output opcode, output task_id, output level, input ready);
  modport sink   (input valid, input opcode, input task_id, input level, output ready);
endinterface

// result channel
interface mrq_out_if import mrq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                popped_valid;
  logic [TASK_W-1:0]   popped_task;
  logic [LEVEL_W-1:0]  popped_level;
  logic [TOTAL_W-1:0]  total_count;

  modport source (output valid, output status, output popped_valid, output popped_task,
                  output popped_level, output total_count, input ready);
  modport sink   (input valid, input status, input popped_valid, input popped_task,
                  input popped_level, input total_count, output ready);
endinterface

// configuration write channel
interface mrq_cfg_if import mrq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] active_levels;

  modport source (output valid, output active_levels, input ready);
  modport sink   (input valid, input active_levels, output ready);
endinterface

// ----- rtl/core/mrq_link_mem.sv -----
`timescale 1ns / 1ps

module mrq_link_mem import mrq_pkg::*; #(
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [TASK_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [TASK_W-1:0] rdata
);

  logic [TASK_W-1:0] link_mem [DEPTH];
  logic [TASK_W-1:0] rdata_r;

  // single write port, registered read (old data on same-address write)
  always_ff @(posedge clk) begin
    if (we) begin
      link_mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= link_mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/mrq_level_table.sv -----
`timescale 1ns / 1ps

module mrq_level_table import mrq_pkg::*; #(
  parameter  int MAX_TASKS = 64,
  parameter  int LEVELS    = 8,
  localparam int CW        = $clog2(MAX_TASKS + 1),
  localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tbl_cmd_t      cmd,
  output tbl_info_t     info,
  output logic [CW-1:0] total
);

  logic [CW-1:0]     count_r [LEVELS];
  logic [TASK_W-1:0] tail_r  [LEVELS];
  logic [CW-1:0]     total_r;

  logic [LEVELS-1:0] nonempty;
  logic              low_valid;
  logic [LW-1:0]     low_idx;
  logic [LW-1:0]     top_idx;
  logic              anchor_valid;
  logic [LW-1:0]     anchor_idx;
  logic [LW-1:0]     ins_idx;

  assign ins_idx = LW'(cmd.level);

  // level occupancy and priority searches
  always_comb begin
    low_valid    = 1'b0;
    low_idx      = '0;
    top_idx      = '0;
    anchor_valid = 1'b0;
    anchor_idx   = '0;
    for (int i = 0; i < LEVELS; i++) begin
      nonempty[i] = (count_r[i] != '0);
    end
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        low_valid = 1'b1;
        low_idx   = LW'(i);
      end
    end
    for (int i = 0; i < LEVELS; i++) begin
      if (nonempty[i]) begin
        top_idx = LW'(i);
      end
      // own level if occupied, else the highest occupied level below it
      if (nonempty[i] && (i <= int'(cmd.level))) begin
        anchor_valid = 1'b1;
        anchor_idx   = LW'(i);
      end
    end
  end

  assign info.anchor_valid = anchor_valid;
  assign info.anchor_tail  = tail_r[anchor_idx];
  assign info.low_valid    = low_valid;
  assign info.low_level    = LEVEL_W'(low_idx);
  assign total             = total_r;

  // counts and running total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        count_r[i] <= '0;
      end
      total_r <= '0;
    end else if (cmd.do_insert) begin
      count_r[ins_idx] <= count_r[ins_idx] + CW'(1);
      total_r          <= total_r + CW'(1);
    end else if (cmd.do_pop) begin
      count_r[low_idx] <= count_r[low_idx] - CW'(1);
      total_r          <= total_r - CW'(1);
    end else if (cmd.do_lift && low_valid) begin
      for (int i = 1; i < LEVELS; i++) begin
        count_r[i] <= '0;
      end
      count_r[0] <= total_r;
    end
  end

  // level tails
  always_ff @(posedge clk) begin
    if (cmd.do_insert) begin
      tail_r[ins_idx] <= cmd.task_id;
    end else if (cmd.do_lift && low_valid) begin
      tail_r[0] <= tail_r[top_idx];
    end
  end

endmodule

// ----- rtl/core/multilevel_ready_queue_unit.sv -----
`timescale 1ns / 1ps

// Multilevel ready queue: task ids queued in one linked order, levels ascending and
// first in, first out within a level, with the links in a single-port-write memory.
// Each request runs in S_RUN and then S_DONE: in S_RUN the level table is updated and
// the link memory is read (tail link for insert, head link for pop); in S_DONE, once
// the result register is free, the read data lands as the new head or the inserted
// task's link and the result is registered. A new request is accepted in that same
// cycle, so it overlaps only the final step of the last one. The result register
// decouples the output side. Reset needs no clearing pass; the link memory is left
// unwritten and is never followed past the queued count.
module multilevel_ready_queue_unit import mrq_pkg::*; #(
  parameter int MAX_TASKS = 64,
  parameter int LEVELS    = 8
) (
  input  logic clk,
  input  logic rst_n,
  mrq_in_if.sink    in_ch,
  mrq_out_if.source out_ch,
  mrq_cfg_if.sink   cfg_ch
);

  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [OP_W-1:0]    op_r;
  logic [TASK_W-1:0]  task_r;
  logic [LEVEL_W-1:0] level_r;
  logic [TASK_W-1:0]  head_r, head_nxt;
  logic [CFG_W-1:0]   active_r;
  logic               link_fix_r, link_fix_nxt;
  logic               head_fix_r, head_fix_nxt;
  res_t               res_r, res_nxt;

  logic               out_valid_r;
  res_t               out_res_r;
  logic [TOTAL_W-1:0] out_total_r;

  logic               out_free;
  logic               accept;
  logic               finish;
  int                 lim;
  logic               bad_level;
  logic               skip_insert;

  tbl_cmd_t           cmd;
  tbl_info_t          info;
  logic [CW-1:0]      total;

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [TASK_W-1:0]  mem_wdata, mem_rdata;

  mrq_link_mem #(.DEPTH(MAX_TASKS)) u_link_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mrq_level_table #(.MAX_TASKS(MAX_TASKS), .LEVELS(LEVELS)) u_level_table (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .info  (info),
    .total (total)
  );

  // handshakes, held off while in reset
  assign out_free     = !out_valid_r || out_ch.ready;
  assign finish       = (state_r == S_DONE) && out_free;
  assign in_ch.ready  = rst_n && ((state_r == S_IDLE) || finish);
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = rst_n;

  // insert checks
  assign lim         = (int'(active_r) < LEVELS) ? int'(active_r) : LEVELS;
  assign bad_level   = int'(level_r) >= lim;
  assign skip_insert = (int'(task_r) >= MAX_TASKS) || (int'(total) >= MAX_TASKS);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_RUN;
      S_RUN:   state_nxt = S_DONE;
      S_DONE: begin
        if (finish) state_nxt = accept ? S_RUN : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // request execution and link memory access
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    head_nxt     = head_r;
    link_fix_nxt = link_fix_r;
    head_fix_nxt = head_fix_r;
    res_nxt      = res_r;
    cmd          = '0;
    cmd.level    = level_r;
    cmd.task_id  = task_r;
    if (state_r == S_RUN) begin
      link_fix_nxt = 1'b0;
      head_fix_nxt = 1'b0;
      res_nxt      = '0;
      case (op_r)
        OP_INSERT: begin
          if (bad_level) begin
            res_nxt.status = ST_BAD_LEVEL;
          end else if (!skip_insert) begin
            cmd.do_insert = 1'b1;
            if (info.anchor_valid) begin
              // splice after the anchor tail: tail points to new, new takes old link
              mem_we       = 1'b1;
              mem_waddr    = AW'(info.anchor_tail);
              mem_wdata    = task_r;
              mem_re       = 1'b1;
              mem_raddr    = AW'(info.anchor_tail);
              link_fix_nxt = (task_r != info.anchor_tail);
            end else begin
              // new head of the whole order
              if (total != '0) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(task_r);
                mem_wdata = head_r;
              end
              head_nxt = task_r;
            end
          end
        end
        OP_POP: begin
          if (!info.low_valid) begin
            res_nxt.status = ST_EMPTY;
          end else begin
            cmd.do_pop           = 1'b1;
            res_nxt.popped_valid = 1'b1;
            res_nxt.popped_task  = head_r;
            res_nxt.popped_level = info.low_level;
            if (total != CW'(1)) begin
              mem_re       = 1'b1;
              mem_raddr    = AW'(head_r);
              head_fix_nxt = 1'b1;
            end
          end
        end
        OP_LIFT: begin
          cmd.do_lift = 1'b1;
        end
        default: ;
      endcase
    end else if (finish) begin
      if (link_fix_r) begin
        mem_we    = 1'b1;
        mem_waddr = AW'(task_r);
        mem_wdata = mem_rdata;
      end
      if (head_fix_r) begin
        head_nxt = mem_rdata;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      active_r    <= ACTIVE_RESET;
      link_fix_r  <= 1'b0;
      head_fix_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      link_fix_r <= link_fix_nxt;
      head_fix_r <= head_fix_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        active_r <= cfg_ch.active_levels;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (accept) begin
      op_r    <= in_ch.opcode;
      task_r  <= in_ch.task_id;
      level_r <= in_ch.level;
    end
    if (finish) begin
      out_res_r   <= res_r;
      out_total_r <= TOTAL_W'(total);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_res_r.status;
  assign out_ch.popped_valid = out_res_r.popped_valid;
  assign out_ch.popped_task  = out_res_r.popped_task;
  assign out_ch.popped_level = out_res_r.popped_level;
  assign out_ch.total_count  = out_total_r;

  // checks
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(total) <= MAX_TASKS)
    else $error("queued total exceeds capacity");

  a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_pop |=> (total == $past(total) - CW'(1)))
    else $error("pop did not remove exactly one task");

  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_RUN))
    else $error("accepted request not executed next cycle");

  a_popped_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.popped_valid) |-> (out_ch.status == ST_OK))
    else $error("popped task reported with error status");

endmodule

// ----- verif/mrq_tb_pkg.sv -----
`timescale 1ns / 1ps

package mrq_tb_pkg;
  import mrq_pkg::*;

  localparam int NUM_TASKS  = 64;
  localparam int NUM_LEVELS = 8;

  // result fields as they appear on the output channel
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                popped_valid;
    logic [TASK_W-1:0]   popped_task;
    logic [LEVEL_W-1:0]  popped_level;
    logic [TOTAL_W-1:0]  total_count;
  } queue_result_t;

  class ready_queue_scoreboard;
    // shadow copy of the queue state
    logic [TASK_W-1:0] link_mem [NUM_TASKS];
    logic [TASK_W-1:0] head;
    logic [TASK_W-1:0] tail [NUM_LEVELS];
    int unsigned       count [NUM_LEVELS];
    logic [CFG_W-1:0]  active_levels;
    // rough membership, only used to steer the stimulus
    bit                queued [NUM_TASKS];
    queue_result_t     pending_results [$];
    int                error_count;

    function new();
      foreach (link_mem[i]) link_mem[i] = '0;
      foreach (tail[i]) tail[i] = '0;
      foreach (count[i]) count[i] = 0;
      foreach (queued[i]) queued[i] = 1'b0;
      head = '0;
      active_levels = ACTIVE_RESET;
      error_count = 0;
    endfunction

    function int unsigned queued_total();
      int unsigned sum;
      sum = 0;
      foreach (count[i]) sum += count[i];
      return sum;
    endfunction

    function int lowest_level();
      for (int i = 0; i < NUM_LEVELS; i++) begin
        if (count[i] != 0) return i;
      end
      return -1;
    endfunction

    function bit is_queued(logic [TASK_W-1:0] t);
      return queued[t];
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void set_active_levels(logic [CFG_W-1:0] value);
      active_levels = value;
    endfunction

    // append a task behind the last task of its level or of the nearest lower level, else at the head
    function status_t insert_task(logic [TASK_W-1:0] t, logic [LEVEL_W-1:0] lvl);
      int unsigned       limit;
      int                below;
      logic [TASK_W-1:0] anchor;
      limit = (int'(active_levels) < NUM_LEVELS) ? int'(active_levels) : NUM_LEVELS;
      if (int'(lvl) >= limit) return ST_BAD_LEVEL;
      if (queued_total() >= NUM_TASKS) return ST_OK;
      below = -1;
      for (int i = int'(lvl); i >= 0; i--) begin
        if (count[i] != 0) begin
          below = i;
          break;
        end
      end
      if (below >= 0) begin
        anchor = tail[below];
        link_mem[t] = link_mem[anchor];
        link_mem[anchor] = t;
      end else begin
        if (queued_total() != 0) link_mem[t] = head;
        head = t;
      end
      tail[lvl] = t;
      count[lvl]++;
      queued[t] = 1'b1;
      return ST_OK;
    endfunction

    // apply one request to the shadow state and return its result
    function queue_result_t update_queue(logic [OP_W-1:0] op, logic [TASK_W-1:0] t,
                                         logic [LEVEL_W-1:0] lvl);
      queue_result_t res;
      int            low;
      int            top;
      int unsigned   sum;
      res = '0;
      res.status = ST_OK;
      case (op)
        OP_INSERT: begin
          res.status = insert_task(t, lvl);
        end
        OP_POP: begin
          low = lowest_level();
          if (low < 0) begin
            res.status = ST_EMPTY;
          end else begin
            res.popped_valid = 1'b1;
            res.popped_task = head;
            res.popped_level = LEVEL_W'(low);
            count[low]--;
            queued[head] = 1'b0;
            if (queued_total() != 0) head = link_mem[head];
          end
        end
        OP_LIFT: begin
          top = -1;
          sum = 0;
          for (int i = 0; i < NUM_LEVELS; i++) begin
            if (count[i] != 0) top = i;
            sum += count[i];
          end
          if (top >= 0) begin
            tail[0] = tail[top];
            for (int i = 1; i < NUM_LEVELS; i++) count[i] = 0;
            count[0] = sum;
          end
        end
        default: ;
      endcase
      res.total_count = TOTAL_W'(queued_total());
      return res;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [TASK_W-1:0] t,
                               logic [LEVEL_W-1:0] lvl);
      pending_results.push_back(update_queue(op, t, lvl));
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] actual);
      if (actual !== want) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, actual);
        error_count++;
      end
    endfunction

    function void check_result(queue_result_t actual);
      queue_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with no request outstanding, expected none, actual %h",
                 $time, actual);
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", 8'(want.status), 8'(actual.status));
      compare_field("popped_valid", 8'(want.popped_valid), 8'(actual.popped_valid));
      compare_field("popped_task", 8'(want.popped_task), 8'(actual.popped_task));
      compare_field("popped_level", 8'(want.popped_level), 8'(actual.popped_level));
      compare_field("total_count", 8'(want.total_count), 8'(actual.total_count));
    endfunction
  endclass

endpackage

// ----- verif/tb_multilevel_ready_queue_unit.sv -----
`timescale 1ns / 1ps

module tb_multilevel_ready_queue_unit;
  import mrq_pkg::*;
  import mrq_tb_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 110;
  localparam logic [CFG_W-1:0] PHASE_LEVELS [NUM_PHASES] = '{8, 3, 1, 8, 5, 15, 2, 0, 7, 8};
  localparam int PHASE_INSERT_PCT [NUM_PHASES] = '{50, 45, 45, 80, 50, 45, 45, 30, 50, 45};

  logic clk = 1'b0;
  logic rst_n;
  int   burst_left;

  mrq_in_if  in_ch ();
  mrq_out_if out_ch ();
  mrq_cfg_if cfg_ch ();

  ready_queue_scoreboard queue_sb = new();

  multilevel_ready_queue_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #1 clk = ~clk;

  // hard stop
  initial begin
    #1000000;
    $display("Verification failed");
    $finish;
  end

  // issue one request, then either stay in the burst or idle for a while
  task automatic send_request(logic [OP_W-1:0] op, logic [TASK_W-1:0] t,
                              logic [LEVEL_W-1:0] lvl);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.task_id <= t;
    in_ch.level <= lvl;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    queue_sb.note_request(op, t, lvl);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 24);
    end
  endtask

  // stop sending until every outstanding result is back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (queue_sb.pending() != 0);
  endtask

  task automatic write_active_levels(logic [CFG_W-1:0] value);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.active_levels <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    queue_sb.set_active_levels(value);
  endtask

  // one random request; counted is low for an unused opcode or a refused level
  task automatic random_request(int insert_pct, output bit counted);
    int                 r;
    int                 limit;
    logic [TASK_W-1:0]  t;
    logic [LEVEL_W-1:0] lvl;
    logic [OP_W-1:0]    op;
    r = $urandom_range(0, 99);
    t = TASK_W'($urandom_range(0, NUM_TASKS - 1));
    lvl = LEVEL_W'($urandom_range(0, NUM_LEVELS - 1));
    limit = (int'(queue_sb.active_levels) < NUM_LEVELS) ? int'(queue_sb.active_levels)
                                                        : NUM_LEVELS;
    if (r < 2) begin
      op = OP_UNUSED;
    end else if (r < 7) begin
      op = OP_LIFT;
    end else if (r < 7 + insert_pct) begin
      op = OP_INSERT;
      // mostly fresh tasks at levels in use, now and then a repeat or a refused level
      if ($urandom_range(0, 99) < 96) begin
        for (int k = 0; k < 8 && queue_sb.is_queued(t); k++) begin
          t = TASK_W'($urandom_range(0, NUM_TASKS - 1));
        end
      end
      if (limit > 0 && $urandom_range(0, 99) < 85) begin
        lvl = LEVEL_W'($urandom_range(0, limit - 1));
      end
    end else begin
      op = OP_POP;
    end
    counted = !(op == OP_UNUSED || (op == OP_INSERT && int'(lvl) >= limit));
    send_request(op, t, lvl);
  endtask

  // result side: check accepted results and stall on a rotating pattern
  initial begin
    int            cycle_no;
    int            mode;
    bit            rdy;
    queue_result_t actual;
    out_ch.ready <= 1'b0;
    cycle_no = 0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        actual.status = out_ch.status;
        actual.popped_valid = out_ch.popped_valid;
        actual.popped_task = out_ch.popped_task;
        actual.popped_level = out_ch.popped_level;
        actual.total_count = out_ch.total_count;
        queue_sb.check_result(actual);
      end
      cycle_no++;
      mode = (cycle_no / 250) % 4;
      case (mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 9) < 7);
        2: rdy = (cycle_no % 6) >= 2;
        default: rdy = (cycle_no % 19) == 0;
      endcase
      out_ch.ready <= rdy;
    end
  end

  // request side
  initial begin
    int counted_items;
    bit counted;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= OP_INSERT;
    in_ch.task_id <= '0;
    in_ch.level <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.active_levels <= ACTIVE_RESET;
    burst_left = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the queue: a level 0 chain in front of one task at level 1
    send_request(OP_INSERT, 63, 1);
    for (int i = 0; i < 63; i++) send_request(OP_INSERT, TASK_W'(i), 0);
    // full queue drops this insert
    send_request(OP_INSERT, 0, 0);
    // empty the queue, with one extra pop on empty
    for (int i = 0; i <= NUM_TASKS; i++) send_request(OP_POP, 0, 0);
    send_request(OP_INSERT, 0, 1);
    send_request(OP_INSERT, 63, 0);
    send_request(OP_POP, 0, 0);
    send_request(OP_POP, 0, 0);

    // empty pop, empty lift, unused opcode
    send_request(OP_POP, 5, 3);
    send_request(OP_LIFT, 0, 0);
    send_request(OP_UNUSED, 63, 7);
    // mixed levels, lift, then insert above the folded level
    send_request(OP_INSERT, 63, 7);
    send_request(OP_INSERT, 0, 3);
    send_request(OP_INSERT, 42, 5);
    send_request(OP_INSERT, 21, 0);
    send_request(OP_INSERT, 7, 3);
    send_request(OP_LIFT, 0, 0);
    send_request(OP_INSERT, 9, 2);
    repeat (3) send_request(OP_POP, 0, 0);
    send_request(OP_INSERT, 5, 7);
    repeat (4) send_request(OP_POP, 0, 0);
    // shrunk level range refuses high levels
    write_active_levels(4);
    send_request(OP_INSERT, 11, 4);
    send_request(OP_INSERT, 12, 7);
    send_request(OP_INSERT, 13, 3);
    // no level in use, yet the task above still pops
    write_active_levels(0);
    send_request(OP_INSERT, 14, 0);
    send_request(OP_POP, 0, 0);
    // oversized setting acts as all levels; same task queued twice
    write_active_levels(15);
    send_request(OP_INSERT, 15, 7);
    send_request(OP_INSERT, 15, 7);
    send_request(OP_POP, 0, 0);
    send_request(OP_POP, 0, 0);

    // random phases, one level setting each
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_active_levels(PHASE_LEVELS[p]);
      counted_items = 0;
      while (counted_items < PHASE_ITEMS) begin
        random_request(PHASE_INSERT_PCT[p], counted);
        if (counted) begin
          counted_items++;
          if (counted_items == PHASE_ITEMS / 2) drain_results();
        end
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (queue_sb.error_count == 0 && queue_sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
